// File: hdl/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, fixed-point constants,
// hue sector codes and the 101-entry value gamma table.
// No dependencies.
package hsv2rgb_pkg;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int CHAN_W = 8;
  localparam int RAMP_W = 10;   // 17 * k for k up to 60
  localparam int PROD_W = 15;   // 255 * 100 and 255 * 65 both fit
  localparam int RECIP_W = 13;
  localparam int QMUL_W = PROD_W + RECIP_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam hue_t  HUE_MAX  = 9'd359;
  localparam pct_t  PCT_MAX  = 7'd100;
  localparam chan_t CHAN_MAX = 8'd255;
  localparam logic [RAMP_W-1:0] RAMP_TOP = 10'd1020;
  localparam logic [4:0]        RAMP_SLOPE = 5'd17;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  localparam hue_t SECT_EDGE_1 = 9'd60;
  localparam hue_t SECT_EDGE_2 = 9'd120;
  localparam hue_t SECT_EDGE_3 = 9'd180;
  localparam hue_t SECT_EDGE_4 = 9'd240;
  localparam hue_t SECT_EDGE_5 = 9'd300;

  typedef enum logic [2:0] {
    SECT_RG_UP,    // red full, green ramps up
    SECT_GR_DOWN,  // green full, red ramps down
    SECT_GB_UP,    // green full, blue ramps up
    SECT_BG_DOWN,  // blue full, green ramps down
    SECT_BR_UP,    // blue full, red ramps up
    SECT_RB_DOWN   // red full, blue ramps down
  } sector_t;

  localparam int NUM_CH = 3;
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // floor(v ^ (1 / 1.1)) for v = 0..100
  localparam pct_t GAMMA_TAB [0:100] = '{
    7'd0,  7'd1,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd5,  7'd6,  7'd7,
    7'd8,  7'd8,  7'd9,  7'd10, 7'd11, 7'd11, 7'd12, 7'd13, 7'd13, 7'd14,
    7'd15, 7'd15, 7'd16, 7'd17, 7'd17, 7'd18, 7'd19, 7'd20, 7'd20, 7'd21,
    7'd22, 7'd22, 7'd23, 7'd24, 7'd24, 7'd25, 7'd25, 7'd26, 7'd27, 7'd27,
    7'd28, 7'd29, 7'd29, 7'd30, 7'd31, 7'd31, 7'd32, 7'd33, 7'd33, 7'd34,
    7'd35, 7'd35, 7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd39, 7'd40, 7'd40,
    7'd41, 7'd41, 7'd42, 7'd43, 7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd46,
    7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd50, 7'd51, 7'd51, 7'd52, 7'd53,
    7'd53, 7'd54, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd57, 7'd58, 7'd59,
    7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd62, 7'd63, 7'd63, 7'd64, 7'd65,
    7'd65
  };

endpackage

// File: hdl/hsv_to_rgb_percent_gamma_core.sv
// HSV to RGB converter with gamma-bent value, five-stage pipeline.
// Depends on hsv2rgb_pkg (widths, constants, sector codes, gamma table).
//
//   Channel | Ports                         | Payload (lowest bit first)
//   --------+-------------------------------+------------------------------------
//   input   | in_tvalid, in_tready, in_tdata | hue[8:0] sat[15:9] bright[22:16]
//   result  | out_tvalid, out_tready,        | red[7:0] green[15:8] blue[23:16]
//           | out_tdata                     |
//
// A request passes through five register stages (sector/ramp/gamma, saturation
// product, divide-by-100 and lift, value product, final divide-by-100); one
// request enters per cycle unless a stalled output has backed up every stage.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up and a stall drops nothing.
// Reset (rst_n low, synchronous) clears only the valid bits.
module hsv_to_rgb_percent_gamma_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // hue[8:0], saturation[15:9], brightness[22:16], bit 23 ignored
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsv2rgb_pkg::*;

  localparam int NSTG = 5;

  // Per-stage valid bits and advance enables
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp inputs, pick the hue sector, build the ramp, look up gamma
  // ---------------------------------------------------------------------
  hue_t    hue_in;
  pct_t    sat_in;
  pct_t    bri_in;
  hue_t    hue_c;
  pct_t    sat_c;
  pct_t    bri_c;
  hue_t    sect_base;
  sector_t sect;
  logic [5:0]        ramp_k;
  logic [RAMP_W-1:0] ramp_17k;
  logic [RAMP_W-1:0] ramp_dn_w;
  chan_t   ramp_up;
  chan_t   ramp_dn;
  chan_t   c1_nxt [NUM_CH];
  pct_t    sinv_nxt;
  pct_t    gv1_nxt;

  assign hue_in = in_tdata[HUE_W-1:0];
  assign sat_in = in_tdata[HUE_W +: PCT_W];
  assign bri_in = in_tdata[HUE_W+PCT_W +: PCT_W];

  always_comb begin
    hue_c = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
    sat_c = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
    bri_c = (bri_in > PCT_MAX) ? PCT_MAX : bri_in;

    // Sector edges belong to the lower sector (hue 60 still ramps green up)
    priority if (hue_c <= SECT_EDGE_1) begin
      sect = SECT_RG_UP;   sect_base = '0;
    end else if (hue_c <= SECT_EDGE_2) begin
      sect = SECT_GR_DOWN; sect_base = SECT_EDGE_1;
    end else if (hue_c <= SECT_EDGE_3) begin
      sect = SECT_GB_UP;   sect_base = SECT_EDGE_2;
    end else if (hue_c <= SECT_EDGE_4) begin
      sect = SECT_BG_DOWN; sect_base = SECT_EDGE_3;
    end else if (hue_c <= SECT_EDGE_5) begin
      sect = SECT_BR_UP;   sect_base = SECT_EDGE_4;
    end else begin
      sect = SECT_RB_DOWN; sect_base = SECT_EDGE_5;
    end

    ramp_k    = 6'(hue_c - sect_base);
    ramp_17k  = RAMP_W'(ramp_k) * RAMP_W'(RAMP_SLOPE);
    ramp_dn_w = RAMP_TOP - ramp_17k;
    ramp_up   = ramp_17k[RAMP_W-1:2];
    ramp_dn   = ramp_dn_w[RAMP_W-1:2];

    unique case (sect)
      SECT_RG_UP: begin
        c1_nxt[CH_R] = CHAN_MAX; c1_nxt[CH_G] = ramp_up;  c1_nxt[CH_B] = '0;
      end
      SECT_GR_DOWN: begin
        c1_nxt[CH_R] = ramp_dn;  c1_nxt[CH_G] = CHAN_MAX; c1_nxt[CH_B] = '0;
      end
      SECT_GB_UP: begin
        c1_nxt[CH_R] = '0;       c1_nxt[CH_G] = CHAN_MAX; c1_nxt[CH_B] = ramp_up;
      end
      SECT_BG_DOWN: begin
        c1_nxt[CH_R] = '0;       c1_nxt[CH_G] = ramp_dn;  c1_nxt[CH_B] = CHAN_MAX;
      end
      SECT_BR_UP: begin
        c1_nxt[CH_R] = ramp_up;  c1_nxt[CH_G] = '0;       c1_nxt[CH_B] = CHAN_MAX;
      end
      default: begin
        c1_nxt[CH_R] = CHAN_MAX; c1_nxt[CH_G] = '0;       c1_nxt[CH_B] = ramp_dn;
      end
    endcase

    sinv_nxt = PCT_MAX - sat_c;
    gv1_nxt  = GAMMA_TAB[bri_c];
  end

  chan_t c1_r [NUM_CH];
  pct_t  sinv_r;
  pct_t  gv1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c1_r   <= c1_nxt;
      sinv_r <= sinv_nxt;
      gv1_r  <= gv1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: saturation product (255 - c) * (100 - s)
  // ---------------------------------------------------------------------
  prod_t prod_nxt [NUM_CH];
  prod_t prod_r   [NUM_CH];
  chan_t c2_r     [NUM_CH];
  pct_t  gv2_r;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod_nxt[i] = PROD_W'(CHAN_MAX - c1_r[i]) * PROD_W'(sinv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod_r <= prod_nxt;
      c2_r   <= c1_r;
      gv2_r  <= gv1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: divide the product by 100 and lift the channel toward white
  // ---------------------------------------------------------------------
  logic [QMUL_W-1:0] lq_mul [NUM_CH];
  chan_t lift_nxt [NUM_CH];
  chan_t lift_r   [NUM_CH];
  pct_t  gv3_r;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      lq_mul[i]   = QMUL_W'(prod_r[i]) * QMUL_W'(RECIP_100);
      lift_nxt[i] = c2_r[i] + lq_mul[i][RECIP_SHIFT +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      lift_r <= lift_nxt;
      gv3_r  <= gv2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: scale by the gamma-bent value
  // ---------------------------------------------------------------------
  prod_t vm_nxt [NUM_CH];
  prod_t vm_r   [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      vm_nxt[i] = PROD_W'(lift_r[i]) * PROD_W'(gv3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      vm_r <= vm_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: final divide by 100 into the output register
  // ---------------------------------------------------------------------
  logic [QMUL_W-1:0] oq_mul [NUM_CH];
  chan_t out_nxt [NUM_CH];
  chan_t out_r   [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      oq_mul[i]  = QMUL_W'(vm_r[i]) * QMUL_W'(RECIP_100);
      out_nxt[i] = oq_mul[i][RECIP_SHIFT +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {out_r[CH_B], out_r[CH_G], out_r[CH_R]};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An accepted request lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted request did not enter stage 1");

  // A full stage blocked from below keeps its lifted channels
  a_lift_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !adv[3]) |=> (v_r[2] && $stable(lift_r[CH_R]) &&
                             $stable(lift_r[CH_G]) && $stable(lift_r[CH_B])))
    else $error("stalled lift stage changed");

  // Saturation products stay below the reciprocal's exact range
  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (prod_r[CH_R] <= 15'd25500 && prod_r[CH_G] <= 15'd25500 &&
                prod_r[CH_B] <= 15'd25500))
    else $error("saturation product out of range");

  // Value products never exceed 255 * 65
  a_vm_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (vm_r[CH_R] <= 15'd16575 && vm_r[CH_G] <= 15'd16575 &&
                vm_r[CH_B] <= 15'd16575))
    else $error("value product out of range");

endmodule
